@@ src/spring_damper_force_core_defines.svh @@
// Assertion macros used by the item queue of the spring damper force core.
`ifndef SPRING_DAMPER_FORCE_CORE_DEFINES_SVH
`define SPRING_DAMPER_FORCE_CORE_DEFINES_SVH

// Checks a condition in the same cycle as its trigger.
`define SDF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks a condition in the cycle after its trigger.
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sdf_pkg.sv @@
// Shared widths, register indexes and item types of the spring damper force core.
package sdf_pkg;

   localparam int COORD_W      = 32;
   localparam int DIFF_W       = 33;
   localparam int MAG_W        = 32;
   localparam int SQ_W         = 64;
   localparam int SUM_W        = 66;
   localparam int ROOT_W       = 34;
   localparam int REM_W        = 68;
   localparam int QUO_W        = 30;
   localparam int CFG_W        = 31;
   localparam int CSR_IDX_W    = 2;
   localparam int FRONT_STAGES = 3;
   localparam int E_FRAC       = 29;
   localparam int Q_FRAC       = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REST      = 2'd2;

   localparam logic [CFG_W-1:0] STIFFNESS_RESET = 31'd65536;
   localparam logic [CFG_W-1:0] DAMPING_RESET   = 31'd0;
   localparam logic [CFG_W-1:0] REST_RESET      = 31'd65536;

   typedef struct packed {
      logic [CFG_W-1:0] stiffness;
      logic [CFG_W-1:0] damping;
      logic [CFG_W-1:0] rest;
   } cfg_type;

   typedef struct packed {
      logic [2:0]              d_neg;
      logic [2:0][MAG_W-1:0]   d_mag;
      logic [2:0][DIFF_W-1:0]  dv;
      logic                    coincident;
   } geom_type;

   typedef struct packed {
      geom_type          geom;
      logic [SUM_W-1:0]  sq_sum;
   } item_type;

   typedef struct packed {
      logic      valid;
      item_type  item;
   } item_beat_type;

   typedef struct packed {
      logic               valid;
      geom_type           geom;
      logic [ROOT_W-1:0]  root;
   } root_beat_type;

endpackage

@@ src/sdf_front.sv @@
// Front end: takes an item, forms separations, relative velocities and the squared length.
module sdf_front import sdf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [2:0][COORD_W-1:0]  pos_one,
   input  logic [2:0][COORD_W-1:0]  pos_two,
   input  logic [2:0][COORD_W-1:0]  vel_one,
   input  logic [2:0][COORD_W-1:0]  vel_two,
   output item_beat_type            beat
);

   logic                    s1_valid_ff, s1_valid_in;
   logic [2:0][DIFF_W-1:0]  s1_d_ff, s1_d_in;
   logic [2:0][DIFF_W-1:0]  s1_dv_ff, s1_dv_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic [2:0]              s2_neg_ff, s2_neg_in;
   logic [2:0][MAG_W-1:0]   s2_mag_ff, s2_mag_in;
   logic [2:0][DIFF_W-1:0]  s2_dv_ff;
   logic [2:0][SQ_W-1:0]    s2_sq_ff, s2_sq_in;
   item_beat_type           beat_ff, beat_in;

   always_comb begin
      s1_valid_in = accept;
      for (int i = 0; i < 3; i++) begin
         s1_d_in[i]  = {pos_two[i][COORD_W-1], pos_two[i]} - {pos_one[i][COORD_W-1], pos_one[i]};
         s1_dv_in[i] = {vel_one[i][COORD_W-1], vel_one[i]} - {vel_two[i][COORD_W-1], vel_two[i]};
      end
   end

   // A difference of two 32-bit values never reaches 2^32 in magnitude.
   always_comb begin
      s2_valid_in = s1_valid_ff;
      for (int i = 0; i < 3; i++) begin
         s2_neg_in[i] = s1_d_ff[i][DIFF_W-1];
         s2_mag_in[i] = s2_neg_in[i] ? MAG_W'(-s1_d_ff[i]) : MAG_W'(s1_d_ff[i]);
         s2_sq_in[i]  = SQ_W'(s2_mag_in[i]) * SQ_W'(s2_mag_in[i]);
      end
   end

   always_comb begin
      beat_in.valid                 = s2_valid_ff;
      beat_in.item.geom.d_neg       = s2_neg_ff;
      beat_in.item.geom.d_mag       = s2_mag_ff;
      beat_in.item.geom.dv          = s2_dv_ff;
      beat_in.item.geom.coincident  = (s2_mag_ff == '0);
      beat_in.item.sq_sum           = SUM_W'(s2_sq_ff[0]) + SUM_W'(s2_sq_ff[1])
                                      + SUM_W'(s2_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      s1_d_ff      <= s1_d_in;
      s1_dv_ff     <= s1_dv_in;
      s2_neg_ff    <= s2_neg_in;
      s2_mag_ff    <= s2_mag_in;
      s2_dv_ff     <= s1_dv_ff;
      s2_sq_ff     <= s2_sq_in;
      beat_ff.item <= beat_in.item;
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         beat_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         beat_ff.valid <= beat_in.valid;
      end
   end

   assign beat = beat_ff;

endmodule

@@ src/sdf_queue.sv @@
// Short item queue between the front end and the square root.
`include "spring_damper_force_core_defines.svh"
module sdf_queue import sdf_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  item_beat_type  push,
   output item_beat_type  pop,
   output logic           busy
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LIMIT = DEPTH - FRONT_STAGES - 1;

   item_type            mem [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pop_valid_ff;
   item_type            pop_item_ff;
   logic                pop_en;

   assign pop_en = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push.valid && !pop_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push.valid && pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.item;
      end
      if (pop_en) begin
         pop_item_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         pop_valid_ff <= pop_en;
      end
   end

   // Leaves room for every item still inside the front end.
   assign busy       = (count_ff > CNT_W'(LIMIT));
   assign pop.valid  = pop_valid_ff;
   assign pop.item   = pop_item_ff;

   `SDF_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `SDF_ASSERT_NOW(a_no_overflow, push.valid && !pop_en, count_ff < CNT_W'(DEPTH), "item pushed into full queue")
   `SDF_ASSERT_NEXT(a_read_follows, pop_en, pop_valid_ff, "queue read did not produce an item")
   `SDF_ASSERT_NEXT(a_count_grows, push.valid && !pop_en, count_ff == $past(count_ff) + CNT_W'(1), "queue count did not grow")

endmodule

@@ src/sdf_root.sv @@
// Pipelined integer square root of the squared separation, one root bit per stage.
module sdf_root import sdf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  item_beat_type  in_beat,
   output root_beat_type  out_beat
);

   logic               valid_ff [ROOT_W];
   logic [REM_W-1:0]   rem_ff   [ROOT_W-1];
   logic [ROOT_W-1:0]  root_ff  [ROOT_W];
   geom_type           geom_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;

      logic               valid_src;
      logic [REM_W-1:0]   rem_src, trial, rem_in;
      logic [ROOT_W-1:0]  root_src, root_in;
      geom_type           geom_src;

      if (k == 0) begin : g_head
         assign valid_src = in_beat.valid;
         assign rem_src   = REM_W'(in_beat.item.sq_sum);
         assign root_src  = '0;
         assign geom_src  = in_beat.item.geom;
      end else begin : g_body
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign geom_src  = geom_ff[k-1];
      end

      // The remainder holds the radicand minus the square of the root so far.
      assign trial = (REM_W'(root_src) << (B + 1)) + (REM_W'(1) << (2 * B));

      always_comb begin
         if (trial <= rem_src) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (ROOT_W'(1) << B);
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         root_ff[k] <= root_in;
         geom_ff[k] <= geom_src;
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_src;
         end
      end

      if (k < ROOT_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
         end
      end
   end

   assign out_beat.valid = valid_ff[ROOT_W-1];
   assign out_beat.geom  = geom_ff[ROOT_W-1];
   assign out_beat.root  = root_ff[ROOT_W-1];

endmodule

@@ src/sdf_back.sv @@
// Back end: direction by pipelined division, axial projection, spring and damper terms, force.
module sdf_back import sdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  root_beat_type         in_beat,
   output logic                  out_valid,
   output logic [COORD_W-1:0]    out_force_x,
   output logic [COORD_W-1:0]    out_force_y,
   output logic [COORD_W-1:0]    out_force_z,
   output logic                  out_coincident
);

   localparam int E_W    = QUO_W + 1;
   localparam int DOT_W  = 64;
   localparam int ST_W   = ROOT_W + 1;
   localparam int PROD_W = CFG_W + ROOT_W;
   localparam int SPR_W  = PROD_W - Q_FRAC;
   localparam int S_W    = SPR_W + 2;
   localparam int SM_W   = S_W - 1;
   localparam int HALF   = 25;
   localparam int PP_W   = HALF + QUO_W;
   localparam int ACC_W  = PP_W + HALF;
   localparam int M_W    = ACC_W - E_FRAC;

   localparam logic [M_W-1:0]     POS_MAX   = M_W'(32'h7FFF_FFFF);
   localparam logic [M_W-1:0]     NEG_MAX   = M_W'(32'h8000_0000);
   localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

   typedef struct packed {
      logic [2:0]              d_neg;
      logic [2:0][DIFF_W-1:0]  dv;
      logic [ROOT_W-1:0]       root;
      logic                    coincident;
   } carry_type;

   // Divider: each component forms |d| * 2^29 / root, one quotient bit per stage.
   logic                    dvalid_ff [QUO_W];
   logic [2:0][ROOT_W-1:0]  drem_ff   [QUO_W-1];
   logic [2:0][QUO_W-1:0]   quo_ff    [QUO_W];
   carry_type               carry_ff  [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int J = QUO_W - 1 - k;

      logic                    valid_src;
      logic [2:0][ROOT_W-1:0]  rem_src, rem_in;
      logic [2:0]              bit_src;
      logic [2:0][QUO_W-1:0]   quo_src, quo_in;
      logic [2:0][ROOT_W:0]    shifted;
      carry_type               carry_src;

      if (k == 0) begin : g_head
         // The quotient is at most 2^29, so the top part of the dividend is below the root.
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_src[i] = ROOT_W'(in_beat.geom.d_mag[i][MAG_W-1:1]);
            assign bit_src[i] = in_beat.geom.d_mag[i][0];
         end
         assign valid_src            = in_beat.valid;
         assign quo_src              = '0;
         assign carry_src.d_neg      = in_beat.geom.d_neg;
         assign carry_src.dv         = in_beat.geom.dv;
         assign carry_src.root       = in_beat.root;
         assign carry_src.coincident = in_beat.geom.coincident;
      end else begin : g_body
         assign valid_src = dvalid_ff[k-1];
         assign rem_src   = drem_ff[k-1];
         assign bit_src   = '0;
         assign quo_src   = quo_ff[k-1];
         assign carry_src = carry_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            shifted[i] = {rem_src[i], bit_src[i]};
            if (shifted[i] >= {1'b0, carry_src.root}) begin
               rem_in[i] = ROOT_W'(shifted[i] - {1'b0, carry_src.root});
               quo_in[i] = quo_src[i] | (QUO_W'(1) << J);
            end else begin
               rem_in[i] = shifted[i][ROOT_W-1:0];
               quo_in[i] = quo_src[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         quo_ff[k]   <= quo_in;
         carry_ff[k] <= carry_src;
         if (reset) begin
            dvalid_ff[k] <= 1'b0;
         end else begin
            dvalid_ff[k] <= valid_src;
         end
      end

      if (k < QUO_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            drem_ff[k] <= rem_in;
         end
      end
   end

   // Stage 1: signed direction times relative velocity.
   logic                   p1_valid_ff;
   logic signed [DOT_W-1:0] p1_prod_ff [3];
   logic signed [DOT_W-1:0] p1_prod_in [3];
   logic [2:0][QUO_W-1:0]  p1_quo_ff;
   logic [2:0]             p1_neg_ff;
   logic [ROOT_W-1:0]      p1_root_ff;
   logic                   p1_coin_ff;
   logic signed [E_W-1:0]  p1_e [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_e[i] = carry_ff[QUO_W-1].d_neg[i] ? -$signed(E_W'(quo_ff[QUO_W-1][i]))
                                              : $signed(E_W'(quo_ff[QUO_W-1][i]));
         p1_prod_in[i] = p1_e[i] * $signed(carry_ff[QUO_W-1].dv[i]);
      end
   end

   // Stage 2: projection and stretch.
   logic                    p2_valid_ff;
   logic [ROOT_W-1:0]       p2_proj_mag_ff, p2_proj_mag_in;
   logic                    p2_proj_neg_ff, p2_proj_neg_in;
   logic [ROOT_W-1:0]       p2_st_mag_ff, p2_st_mag_in;
   logic                    p2_st_neg_ff, p2_st_neg_in;
   logic [2:0][QUO_W-1:0]   p2_quo_ff;
   logic [2:0]              p2_neg_ff;
   logic                    p2_coin_ff;
   logic signed [DOT_W-1:0] p2_dot;
   logic [DOT_W-1:0]        p2_dot_mag;
   logic [ST_W-1:0]         p2_stretch;

   always_comb begin
      p2_dot         = p1_prod_ff[0] + p1_prod_ff[1] + p1_prod_ff[2];
      p2_proj_neg_in = p2_dot[DOT_W-1];
      p2_dot_mag     = p2_proj_neg_in ? DOT_W'(-p2_dot) : DOT_W'(p2_dot);
      p2_proj_mag_in = ROOT_W'(p2_dot_mag >> E_FRAC);
      p2_stretch     = {1'b0, p1_root_ff} - ST_W'(cfg.rest);
      p2_st_neg_in   = p2_stretch[ST_W-1];
      p2_st_mag_in   = p2_st_neg_in ? ROOT_W'(-p2_stretch) : ROOT_W'(p2_stretch);
   end

   // Stage 3: spring and damper magnitudes.
   logic                  p3_valid_ff;
   logic [SPR_W-1:0]      p3_spring_ff, p3_spring_in;
   logic [SPR_W-1:0]      p3_damp_ff, p3_damp_in;
   logic                  p3_sp_neg_ff, p3_dm_neg_ff;
   logic [2:0][QUO_W-1:0] p3_quo_ff;
   logic [2:0]            p3_neg_ff;
   logic                  p3_coin_ff;

   always_comb begin
      p3_spring_in = SPR_W'((PROD_W'(cfg.stiffness) * PROD_W'(p2_st_mag_ff)) >> Q_FRAC);
      p3_damp_in   = SPR_W'((PROD_W'(cfg.damping) * PROD_W'(p2_proj_mag_ff)) >> Q_FRAC);
   end

   // Stage 4: axial force, spring minus damper.
   logic                  p4_valid_ff;
   logic [S_W-1:0]        p4_s_ff, p4_s_in;
   logic [2:0][QUO_W-1:0] p4_quo_ff;
   logic [2:0]            p4_neg_ff;
   logic                  p4_coin_ff;
   logic [S_W-1:0]        p4_sp, p4_dm;

   always_comb begin
      p4_sp   = p3_sp_neg_ff ? -S_W'(p3_spring_ff) : S_W'(p3_spring_ff);
      p4_dm   = p3_dm_neg_ff ? -S_W'(p3_damp_ff) : S_W'(p3_damp_ff);
      p4_s_in = p4_sp - p4_dm;
   end

   // Stage 5: sign and magnitude of the axial force.
   logic                  p5_valid_ff;
   logic [SM_W-1:0]       p5_mag_ff, p5_mag_in;
   logic                  p5_s_neg_ff;
   logic [2:0][QUO_W-1:0] p5_quo_ff;
   logic [2:0]            p5_neg_ff;
   logic                  p5_coin_ff;

   assign p5_mag_in = p4_s_ff[S_W-1] ? SM_W'(-p4_s_ff) : SM_W'(p4_s_ff);

   // Stage 6: the wide product is split into two partial products.
   logic                 p6_valid_ff;
   logic [2:0][PP_W-1:0] p6_hi_ff, p6_hi_in;
   logic [2:0][PP_W-1:0] p6_lo_ff, p6_lo_in;
   logic [2:0]           p6_fneg_ff, p6_fneg_in;
   logic                 p6_coin_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p6_hi_in[i]   = PP_W'(p5_mag_ff[SM_W-1:HALF]) * PP_W'(p5_quo_ff[i]);
         p6_lo_in[i]   = PP_W'(p5_mag_ff[HALF-1:0]) * PP_W'(p5_quo_ff[i]);
         p6_fneg_in[i] = p5_s_neg_ff ^ p5_neg_ff[i];
      end
   end

   // Stage 7: recombine, scale and saturate.
   logic                    out_valid_ff;
   logic [2:0][COORD_W-1:0] force_ff, force_in;
   logic                    coin_ff;
   logic [2:0][ACC_W-1:0]   p7_acc;
   logic [2:0][M_W-1:0]     p7_m;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p7_acc[i] = (ACC_W'(p6_hi_ff[i]) << HALF) + ACC_W'(p6_lo_ff[i]);
         p7_m[i]   = M_W'(p7_acc[i] >> E_FRAC);
         if (p6_coin_ff) begin
            force_in[i] = '0;
         end else if (p6_fneg_ff[i]) begin
            force_in[i] = (p7_m[i] > NEG_MAX) ? NEG_LIMIT : COORD_W'(-p7_m[i]);
         end else begin
            force_in[i] = (p7_m[i] > POS_MAX) ? POS_LIMIT : p7_m[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         p1_prod_ff[i] <= p1_prod_in[i];
      end
      p1_quo_ff      <= quo_ff[QUO_W-1];
      p1_neg_ff      <= carry_ff[QUO_W-1].d_neg;
      p1_root_ff     <= carry_ff[QUO_W-1].root;
      p1_coin_ff     <= carry_ff[QUO_W-1].coincident;

      p2_proj_mag_ff <= p2_proj_mag_in;
      p2_proj_neg_ff <= p2_proj_neg_in;
      p2_st_mag_ff   <= p2_st_mag_in;
      p2_st_neg_ff   <= p2_st_neg_in;
      p2_quo_ff      <= p1_quo_ff;
      p2_neg_ff      <= p1_neg_ff;
      p2_coin_ff     <= p1_coin_ff;

      p3_spring_ff   <= p3_spring_in;
      p3_damp_ff     <= p3_damp_in;
      p3_sp_neg_ff   <= p2_st_neg_ff;
      p3_dm_neg_ff   <= p2_proj_neg_ff;
      p3_quo_ff      <= p2_quo_ff;
      p3_neg_ff      <= p2_neg_ff;
      p3_coin_ff     <= p2_coin_ff;

      p4_s_ff        <= p4_s_in;
      p4_quo_ff      <= p3_quo_ff;
      p4_neg_ff      <= p3_neg_ff;
      p4_coin_ff     <= p3_coin_ff;

      p5_mag_ff      <= p5_mag_in;
      p5_s_neg_ff    <= p4_s_ff[S_W-1];
      p5_quo_ff      <= p4_quo_ff;
      p5_neg_ff      <= p4_neg_ff;
      p5_coin_ff     <= p4_coin_ff;

      p6_hi_ff       <= p6_hi_in;
      p6_lo_ff       <= p6_lo_in;
      p6_fneg_ff     <= p6_fneg_in;
      p6_coin_ff     <= p5_coin_ff;

      force_ff       <= force_in;
      coin_ff        <= p6_coin_ff;

      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         p5_valid_ff  <= 1'b0;
         p6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= dvalid_ff[QUO_W-1];
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         p4_valid_ff  <= p3_valid_ff;
         p5_valid_ff  <= p4_valid_ff;
         p6_valid_ff  <= p5_valid_ff;
         out_valid_ff <= p6_valid_ff;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_force_x    = force_ff[0];
   assign out_force_y    = force_ff[1];
   assign out_force_z    = force_ff[2];
   assign out_coincident = coin_ff;

endmodule

@@ src/spring_damper_force_core.sv @@
// Top level of the spring damper force core: register port and the front, queue, root and back.
//
//   channel   handshake            payload
//   request   start / busy         req_first_pos_*, req_second_pos_*, req_first_vel_*, ...
//   response  rsp_valid strobe     rsp_force_x/y/z, rsp_coincident
//   csr       csr_wr_en            csr_index, csr_wdata
//
// One item is taken per cycle while busy is low.
// A result passes the front end, the queue, the 34-stage square root, the 30-stage divider and the back end.
// busy rises only if the item queue nears full; results are never held back.
// Reset is synchronous and clears all valid flags and the registers to their defaults.
module spring_damper_force_core import sdf_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_W-1:0]    req_first_pos_x,
   input  logic [COORD_W-1:0]    req_first_pos_y,
   input  logic [COORD_W-1:0]    req_first_pos_z,
   input  logic [COORD_W-1:0]    req_second_pos_x,
   input  logic [COORD_W-1:0]    req_second_pos_y,
   input  logic [COORD_W-1:0]    req_second_pos_z,
   input  logic [COORD_W-1:0]    req_first_vel_x,
   input  logic [COORD_W-1:0]    req_first_vel_y,
   input  logic [COORD_W-1:0]    req_first_vel_z,
   input  logic [COORD_W-1:0]    req_second_vel_x,
   input  logic [COORD_W-1:0]    req_second_vel_y,
   input  logic [COORD_W-1:0]    req_second_vel_z,
   output logic                  rsp_valid,
   output logic [COORD_W-1:0]    rsp_force_x,
   output logic [COORD_W-1:0]    rsp_force_y,
   output logic [COORD_W-1:0]    rsp_force_z,
   output logic                  rsp_coincident,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   item_beat_type  front_beat;
   item_beat_type  queue_beat;
   root_beat_type  root_beat;
   logic           accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STIFFNESS: cfg_in.stiffness = csr_wdata;
            CSR_DAMPING:   cfg_in.damping   = csr_wdata;
            CSR_REST:      cfg_in.rest      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{STIFFNESS_RESET, DAMPING_RESET, REST_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = start && !busy;

   sdf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .pos_one ({req_first_pos_z, req_first_pos_y, req_first_pos_x}),
      .pos_two ({req_second_pos_z, req_second_pos_y, req_second_pos_x}),
      .vel_one ({req_first_vel_z, req_first_vel_y, req_first_vel_x}),
      .vel_two ({req_second_vel_z, req_second_vel_y, req_second_vel_x}),
      .beat    (front_beat)
   );

   sdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_beat),
      .pop   (queue_beat),
      .busy  (busy)
   );

   sdf_root u_root (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (queue_beat),
      .out_beat (root_beat)
   );

   sdf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_beat        (root_beat),
      .out_valid      (rsp_valid),
      .out_force_x    (rsp_force_x),
      .out_force_y    (rsp_force_y),
      .out_force_z    (rsp_force_z),
      .out_coincident (rsp_coincident)
   );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the spring damper force core.
`timescale 1ns / 100ps

module testbench;
   import sdf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 90;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] fp;
      logic [2:0][COORD_W-1:0] sp;
      logic [2:0][COORD_W-1:0] fv;
      logic [2:0][COORD_W-1:0] sv;
   } bodies_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] f;
      logic                    coincident;
   } force_type;

   typedef struct {
      bodies_type b;
      bit         typed;
      force_type  want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bodies_type req = '0;
   logic rsp_valid;
   logic [COORD_W-1:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic rsp_coincident;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   logic [CFG_W-1:0] stiffness_reg = STIFFNESS_RESET;
   logic [CFG_W-1:0] damping_reg = DAMPING_RESET;
   logic [CFG_W-1:0] rest_reg = REST_RESET;

   force_type pending_forces[$];
   int failures = 0;
   int idle_pct = 0;

   always #6 clock = ~clock;

   spring_damper_force_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_pos_x(req.fp[0]), .req_first_pos_y(req.fp[1]), .req_first_pos_z(req.fp[2]),
      .req_second_pos_x(req.sp[0]), .req_second_pos_y(req.sp[1]), .req_second_pos_z(req.sp[2]),
      .req_first_vel_x(req.fv[0]), .req_first_vel_y(req.fv[1]), .req_first_vel_z(req.fv[2]),
      .req_second_vel_x(req.sv[0]), .req_second_vel_y(req.sv[1]),
      .req_second_vel_z(req.sv[2]),
      .rsp_valid(rsp_valid), .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y),
      .rsp_force_z(rsp_force_z), .rsp_coincident(rsp_coincident),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic logic [127:0] mag128(logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic force_type predict_force(bodies_type b);
      logic signed [127:0] d[3], dv[3], e[3];
      logic signed [127:0] a, c2, dot, proj, stretch, spring, damp, s;
      logic [127:0] sq, root, cand, m;
      force_type res;
      bit neg;
      sq = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         a = $signed(b.sp[i]);
         c2 = $signed(b.fp[i]);
         d[i] = a - c2;
         a = $signed(b.fv[i]);
         c2 = $signed(b.sv[i]);
         dv[i] = a - c2;
         sq += mag128(d[i]) * mag128(d[i]);
      end
      res = '0;
      if (sq == 0) begin
         res.coincident = 1'b1;
         return res;
      end
      root = 0;
      for (int k = 33; k >= 0; k--) begin
         cand = root | (128'd1 << k);
         if (cand * cand <= sq) root = cand;
      end
      for (int i = 0; i < 3; i++) begin
         m = (mag128(d[i]) << E_FRAC) / root;
         e[i] = d[i] < 0 ? -$signed(m) : $signed(m);
         dot += e[i] * dv[i];
      end
      m = mag128(dot) >> E_FRAC;
      proj = dot < 0 ? -$signed(m) : $signed(m);
      stretch = $signed(root) - $signed({97'd0, rest_reg});
      m = ({97'd0, stiffness_reg} * mag128(stretch)) >> Q_FRAC;
      spring = stretch < 0 ? -$signed(m) : $signed(m);
      m = ({97'd0, damping_reg} * mag128(proj)) >> Q_FRAC;
      damp = proj < 0 ? -$signed(m) : $signed(m);
      s = spring - damp;
      for (int i = 0; i < 3; i++) begin
         neg = (s < 0) != (e[i] < 0);
         m = (mag128(s) * mag128(e[i])) >> E_FRAC;
         if (neg) res.f[i] = m > 128'h8000_0000 ? 32'h8000_0000 : 32'(-m);
         else res.f[i] = m > 128'h7fff_ffff ? 32'h7fff_ffff : 32'(m);
      end
      return res;
   endfunction

   // Results cannot be held off, so every strobe is checked at the edge that ends it.
   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_valid) begin
         if (pending_forces.size() == 0) begin
            $error("unexpected result x=%h y=%h z=%h", rsp_force_x, rsp_force_y, rsp_force_z);
            failures++;
         end else begin
            want = pending_forces.pop_front();
            if (rsp_force_x !== want.f[0]) begin
               $error("force_x expected %h actual %h", want.f[0], rsp_force_x);
               failures++;
            end
            if (rsp_force_y !== want.f[1]) begin
               $error("force_y expected %h actual %h", want.f[1], rsp_force_y);
               failures++;
            end
            if (rsp_force_z !== want.f[2]) begin
               $error("force_z expected %h actual %h", want.f[2], rsp_force_z);
               failures++;
            end
            if (rsp_coincident !== want.coincident) begin
               $error("coincident expected %b actual %b", want.coincident, rsp_coincident);
               failures++;
            end
         end
      end
   end

   // The write enable drops after each write and stays low until the task returns.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_STIFFNESS: stiffness_reg = val;
         CSR_DAMPING:   damping_reg = val;
         CSR_REST:      rest_reg = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Holds start high from the current edge until the item is taken.
   task automatic send_item(bodies_type b, bit typed, force_type want);
      start <= 1'b1;
      req <= b;
      do @(posedge clock); while (busy);
      pending_forces.push_back(typed ? want : predict_force(b));
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic bodies_type random_bodies();
      bodies_type b;
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         b.fp[i] = $urandom;
         b.fv[i] = $urandom;
         b.sv[i] = $urandom;
         case (kind)
            0, 1, 2: b.sp[i] = $urandom;
            3: b.sp[i] = b.fp[i];
            default: b.sp[i] = b.fp[i] + $signed($urandom_range(0, 32'h0008_0000))
                               - 32'h0004_0000;
         endcase
         if (kind >= 6) begin
            b.fv[i] = $signed(b.fv[i]) >>> 12;
            b.sv[i] = $signed(b.sv[i]) >>> 12;
         end
      end
      return b;
   endfunction

   function automatic bodies_type make_bodies(logic [COORD_W-1:0] p1, logic [COORD_W-1:0] p2,
                                              logic [COORD_W-1:0] v1, logic [COORD_W-1:0] v2);
      bodies_type b;
      b = '0;
      b.fp[0] = p1;
      b.sp[0] = p2;
      b.fv[0] = v1;
      b.sv[0] = v2;
      return b;
   endfunction

   initial begin
      row_type rows[$];
      row_type r;
      force_type none;
      int idles[5] = '{0, 60, 0, 17, 35};
      none = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults: unit stiffness and rest length, no damping.
      r.typed = 1;
      r.b = '0;
      r.want = '{f: '0, coincident: 1'b1};
      rows.push_back(r);
      r.b = make_bodies(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      rows.push_back(r);
      r.b = make_bodies(0, 32'h0001_0000, 0, 0);
      r.want = '{f: '0, coincident: 1'b0};
      rows.push_back(r);
      r.b = make_bodies(0, 32'h0002_0000, 0, 0);
      r.want.f[0] = 32'h0001_0000;
      rows.push_back(r);
      r.typed = 0;
      r.b = make_bodies(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      rows.push_back(r);
      r.b = make_bodies(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      rows.push_back(r);
      r.b = '{fp: {3{32'h8000_0000}}, sp: {3{32'h7fff_ffff}},
              fv: {3{32'hffff_ffff}}, sv: {3{32'h0000_0001}}};
      rows.push_back(r);
      r.b = make_bodies(0, 1, 0, 0);
      rows.push_back(r);
      r.b = make_bodies(0, 32'hffff_ffff, 32'h0001_0000, 0);
      rows.push_back(r);
      foreach (rows[i]) send_item(rows[i].b, rows[i].typed, rows[i].want);
      start <= 1'b0;
      drain();

      // Extreme registers with the same edge cases.
      write_reg(CSR_STIFFNESS, 31'h7fff_ffff);
      write_reg(CSR_DAMPING, 31'h7fff_ffff);
      write_reg(CSR_REST, 31'd0);
      write_reg(CSR_UNUSED, 31'h1234_5678);
      foreach (rows[i]) send_item(rows[i].b, 1'b0, none);
      start <= 1'b0;
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_STIFFNESS, 31'd0);
               write_reg(CSR_DAMPING, 31'd0);
               write_reg(CSR_REST, 31'h7fff_ffff);
            end
            1, 3: begin
               write_reg(CSR_STIFFNESS, CFG_W'($urandom_range(0, 32'h0010_0000)));
               write_reg(CSR_DAMPING, CFG_W'($urandom_range(0, 32'h0010_0000)));
               write_reg(CSR_REST, CFG_W'($urandom_range(0, 32'h0010_0000)));
            end
            default: begin
               write_reg(CSR_STIFFNESS, CFG_W'($urandom));
               write_reg(CSR_DAMPING, CFG_W'($urandom));
               write_reg(CSR_REST, CFG_W'($urandom));
            end
         endcase
         idle_pct = idles[ph];
         repeat (180) send_item(random_bodies(), 1'b0, none);
         start <= 1'b0;
         drain();
      end

      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #(12 * 200000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/sdf_pkg.sv
src/sdf_front.sv
src/sdf_queue.sv
src/sdf_root.sv
src/sdf_back.sv
src/spring_damper_force_core.sv
bench/testbench.sv
